// ----- hw/rtl/sofdd_pkg.sv -----
`default_nettype none

package sofdd_pkg;

    localparam logic [7:0] SOF_BYTE      = 8'hA5;
    localparam logic [5:0] PAYLOAD_START = 6'd7;
    localparam logic [5:0] MAX_RESULTS   = 6'd56;
    localparam logic [5:0] MAX_LEN_RESET = 6'd50;
    localparam logic [2:0] HDR_LAST_STEP = 3'd4;

    localparam logic [15:0] CMD_GAME_STATUS = 16'h0001;
    localparam logic [15:0] CMD_ROBOT_STATE = 16'h0201;
    localparam logic [15:0] CMD_POWER_HEAT  = 16'h0202;
    localparam logic [15:0] CMD_SHOOT_DATA  = 16'h0207;
    localparam logic [15:0] CMD_SITE_EVENT  = 16'h0105;
    localparam logic [15:0] CMD_RFID_STATUS = 16'h020A;

    localparam logic [2:0] DEST_UNKNOWN     = 3'd0;
    localparam logic [2:0] DEST_GAME_STATUS = 3'd1;
    localparam logic [2:0] DEST_ROBOT_STATE = 3'd2;
    localparam logic [2:0] DEST_POWER_HEAT  = 3'd3;
    localparam logic [2:0] DEST_SHOOT_DATA  = 3'd4;
    localparam logic [2:0] DEST_SITE_EVENT  = 3'd5;
    localparam logic [2:0] DEST_RFID_STATUS = 3'd6;

    typedef struct packed {
        logic [15:0] command_id;
        logic [7:0]  sequence_number;
        logic [2:0]  destination_code;
        logic        has_payload;
        logic [5:0]  payload_index;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
    } t_result;

    function automatic logic [2:0] dest_of(input logic [15:0] cmd);
        logic [2:0] d;
        unique case (cmd)
            CMD_GAME_STATUS: d = DEST_GAME_STATUS;
            CMD_ROBOT_STATE: d = DEST_ROBOT_STATE;
            CMD_POWER_HEAT:  d = DEST_POWER_HEAT;
            CMD_SHOOT_DATA:  d = DEST_SHOOT_DATA;
            CMD_SITE_EVENT:  d = DEST_SITE_EVENT;
            CMD_RFID_STATUS: d = DEST_RFID_STATUS;
            default:         d = DEST_UNKNOWN;
        endcase
        return d;
    endfunction

    // Header buffer positions read in order: length lo/hi, sequence, command lo/hi
    function automatic logic [5:0] hdr_pos(input logic [2:0] step);
        logic [5:0] p;
        unique case (step)
            3'd0:    p = 6'd1;
            3'd1:    p = 6'd2;
            3'd2:    p = 6'd3;
            3'd3:    p = 6'd5;
            default: p = 6'd6;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sofdd_chan_if.sv -----
`default_nettype none

interface sofdd_chan_if #(
    parameter type t_data = logic [7:0]
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sof_frame_deframer_dispatch.sv -----
`default_nettype none

// Channel   Dir   Payload                      Transfer
// i_rx      in    rx_byte [7:0]                valid & ready
// o_res     out   sofdd_pkg::t_result          valid & ready
// i_cfg     in    max_payload_length [5:0]     valid & ready (always ready)
//
// A byte that does not close a frame leaves the state at S_IDLE, so i_rx stays ready.
// A delimiter that closes a frame runs the header reads (S_HDR), S_HWAIT and
// the length check (S_CHECK), then per result a buffer read (S_RD), a load
// (S_LD) and the transfer; i_rx is held off until the last result is loaded.
// Reset is synchronous; buffer valid bits clear in the same cycle, no sweep.
// A stalled o_res holds its result and, during a frame end, stalls the read-out.
module sof_frame_deframer_dispatch #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    sofdd_chan_if.sink   i_rx,
    sofdd_chan_if.sink   i_cfg,
    sofdd_chan_if.source o_res
);

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int WPW = $clog2(BUFFER_DEPTH + 1);
    localparam int PW  = (AW > 6) ? AW : 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_HWAIT,
        S_CHECK,
        S_RD,
        S_LD
    } t_state;

    t_state             r_state;
    logic               r_started;
    logic [WPW-1:0]     r_wpos;
    logic [5:0]         r_max;
    logic [2:0]         r_step;
    logic [7:0]         r_hdr [5];
    logic [2:0]         r_cap_step;
    logic               r_cap_pend;
    logic [5:0]         r_k;
    logic [5:0]         r_cnt;
    logic               r_nz;
    logic [2:0]         r_dest;
    logic               r_out_valid;
    sofdd_pkg::t_result r_out;

    logic [7:0]         r_mem [BUFFER_DEPTH];
    logic [BUFFER_DEPTH-1:0] r_vld;
    logic [7:0]         r_rd_data;
    logic               r_rd_ok;

    logic               in_acc;
    logic               is_sof;
    logic               wr_en;
    logic [WPW-1:0]     wr_pos;
    logic               rd_en;
    logic [PW-1:0]      rd_pos;
    logic               rd_in_range;
    logic [7:0]         rd_byte;
    logic [15:0]        hdr_len;
    logic [15:0]        hdr_cmd;
    logic [5:0]         limit;

    assign in_acc = i_rx.valid && i_rx.ready;
    assign is_sof = (i_rx.data == sofdd_pkg::SOF_BYTE);

    assign i_rx.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // A delimiter always lands at position 0; other bytes only inside a frame
    assign wr_pos = is_sof ? '0 : r_wpos;
    assign wr_en  = in_acc && (is_sof || (r_started && (r_wpos < WPW'(BUFFER_DEPTH))));

    assign rd_en  = (r_state == S_HDR) || ((r_state == S_RD) && !r_out_valid);
    assign rd_pos = (r_state == S_HDR) ? PW'(sofdd_pkg::hdr_pos(r_step))
                                       : PW'(sofdd_pkg::PAYLOAD_START + r_k);
    assign rd_in_range = ({1'b0, rd_pos} < (PW + 1)'(BUFFER_DEPTH));
    assign rd_byte     = r_rd_ok ? r_rd_data : 8'h00;

    assign hdr_len = {r_hdr[1], r_hdr[0]};
    assign hdr_cmd = {r_hdr[4], r_hdr[3]};
    assign limit   = (r_max > sofdd_pkg::MAX_RESULTS) ? sofdd_pkg::MAX_RESULTS : r_max;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_pos[AW-1:0]] <= i_rx.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_pos[AW-1:0]];
            r_rd_ok   <= rd_in_range && r_vld[rd_pos[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_pos[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_wpos      <= '0;
            r_max       <= sofdd_pkg::MAX_LEN_RESET;
            r_step      <= '0;
            r_cap_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_max <= i_cfg.data;
            end

            if (wr_en) begin
                r_wpos <= wr_pos + WPW'(1);
            end
            if (in_acc && is_sof) begin
                r_started <= 1'b1;
            end

            // Capture the header byte read in the previous cycle
            r_cap_pend <= (r_state == S_HDR);
            r_cap_step <= r_step;
            if (r_cap_pend) begin
                r_hdr[r_cap_step] <= rd_byte;
            end

            if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && is_sof && r_started) begin
                        r_step  <= '0;
                        r_state <= S_HDR;
                    end
                end
                S_HDR: begin
                    if (r_step == sofdd_pkg::HDR_LAST_STEP) begin
                        r_state <= S_HWAIT;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_HWAIT: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_dest <= sofdd_pkg::dest_of(hdr_cmd);
                    r_k    <= '0;
                    r_nz   <= (hdr_len != 16'd0);
                    r_cnt  <= (hdr_len == 16'd0) ? 6'd1 : hdr_len[5:0];
                    // Drop oversized frames without any result
                    if (hdr_len > {10'd0, limit}) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (!r_out_valid) begin
                        r_state <= S_LD;
                    end
                end
                S_LD: begin
                    r_out_valid             <= 1'b1;
                    r_out.command_id        <= hdr_cmd;
                    r_out.sequence_number   <= r_hdr[2];
                    r_out.destination_code  <= r_dest;
                    r_out.has_payload       <= r_nz;
                    r_out.payload_index     <= r_nz ? r_k : 6'd0;
                    r_out.payload_byte      <= r_nz ? rd_byte : 8'h00;
                    r_out.last_of_frame     <= (r_k + 6'd1 == r_cnt);
                    if (r_k + 6'd1 == r_cnt) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 6'd1;
                        r_state <= S_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_wpos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpos <= WPW'(BUFFER_DEPTH))
        else $error("write position past buffer depth");

    a_idle_wpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> (r_wpos == '0))
        else $error("bytes stored before first delimiter");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LD) |-> !r_out_valid)
        else $error("result loaded over a pending result");

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LD) |-> (r_k < r_cnt))
        else $error("result index past frame count");

    a_read_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) && !r_out_valid |=> (r_state == S_LD))
        else $error("payload read not followed by load");

endmodule

`default_nettype wire
